// File: rtl/tdsn_pkg.sv
package tdsn_pkg;

	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned MAX_OUT   = 4;
	localparam int unsigned CNT_W     = $clog2(MAX_OUT + 1);
	localparam int unsigned QDEPTH    = 4;
	localparam int unsigned QPTR_W    = $clog2(QDEPTH);
	localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [CHAR_W-1:0] CH_QUEST  = 8'h3F; // ?
	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28; // (
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29; // )
	localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F; // /
	localparam logic [CHAR_W-1:0] CH_APOS   = 8'h27; // '
	localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C; // <
	localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E; // >
	localparam logic [CHAR_W-1:0] CH_BANG   = 8'h21; // !
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D; // -
	localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D; // =
	localparam logic [CHAR_W-1:0] CH_PCT    = 8'h25; // %
	localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A; // :
	localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B; // [
	localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D; // ]
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C; // backslash
	localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E; // ^
	localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B; // {
	localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D; // }
	localparam logic [CHAR_W-1:0] CH_PIPE   = 8'h7C; // |
	localparam logic [CHAR_W-1:0] CH_TILDE  = 8'h7E; // ~
	localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23; // #
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_VT     = 8'h0B;
	localparam logic [CHAR_W-1:0] CH_FF     = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_NONE   = 8'h00;

	// Output bytes of one accepted item, in order, with their count (1..MAX_OUT).
	typedef struct packed {
		logic [MAX_OUT-1:0][CHAR_W-1:0] bytes;
		logic [CNT_W-1:0]               cnt;
	} bundle_t;

	function automatic logic is_blank(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
			(c == CH_FF) || (c == CH_CR);
	endfunction

	function automatic logic is_lead(input logic [CHAR_W-1:0] c);
		return (c == CH_QUEST) || (c == CH_LT) || (c == CH_COLON) || (c == CH_PCT);
	endfunction

	// Third character of a trigraph to its replacement, or CH_NONE.
	function automatic logic [CHAR_W-1:0] tri_map(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = CH_NONE;
		unique case (c)
			CH_LPAREN: r = CH_LBRACK;
			CH_RPAREN: r = CH_RBRACK;
			CH_SLASH:  r = CH_BSLASH;
			CH_APOS:   r = CH_CARET;
			CH_LT:     r = CH_LBRACE;
			CH_GT:     r = CH_RBRACE;
			CH_BANG:   r = CH_PIPE;
			CH_MINUS:  r = CH_TILDE;
			CH_EQ:     r = CH_HASH;
			default:   r = CH_NONE;
		endcase
		return r;
	endfunction

	// Digraph pair to its replacement, or CH_NONE.
	function automatic logic [CHAR_W-1:0] di_map(input logic [CHAR_W-1:0] a,
			input logic [CHAR_W-1:0] b);
		logic [CHAR_W-1:0] r;
		r = CH_NONE;
		priority if (a == CH_LT && b == CH_PCT)      r = CH_LBRACE;
		else if (a == CH_LT && b == CH_COLON)        r = CH_LBRACK;
		else if (a == CH_PCT && b == CH_GT)          r = CH_RBRACE;
		else if (a == CH_PCT && b == CH_COLON)       r = CH_HASH;
		else if (a == CH_COLON && b == CH_GT)        r = CH_RBRACK;
		else                                         r = CH_NONE;
		return r;
	endfunction

endpackage

// File: rtl/trigraph_digraph_space_normalizer_core.sv
// Trigraph, digraph and whitespace normalizer for C-style source bytes.
// Slave channel: one source byte per item in s_tdata; s_tuser high marks end
// of input, which flushes held lookahead and a pending space (s_tdata ignored).
// Master channel: one normalized byte per item in m_tdata; m_tlast is high on
// the final byte produced by one input item. An input item may produce zero
// to four output items; a zero-output item leaves no trace on the master side.
// With the queue and output register empty, an accepted item is written to
// the queue and then loaded into the output register before m_tvalid rises.
// Throughput: one input item per cycle while each item yields at most one byte
// and m_tready stays high; an item that yields several bytes holds the output
// serializer until its last byte is loaded, with up to four translated items
// buffered between the scanner and the serializer.
// Reset (arst_n low) clears held lookahead, the pending space, the queue and
// the output register. When m_tready is low the output register holds, the
// queue fills, and s_tready drops only once the queue is full.
module trigraph_digraph_space_normalizer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] in_char
	input  logic [0:0] s_tuser,  // [0] end_of_input
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_char
	output logic       m_tlast   // last_of_run
);
	import tdsn_pkg::*;

	logic    push;
	bundle_t push_data;
	logic    q_full;
	logic    pop;
	logic    head_valid;
	bundle_t head;

	// Scan and translate; advance lookahead state per accepted item.
	tdsn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_char   (s_tdata),
		.in_eoi    (s_tuser[0]),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	// Buffer translated byte groups so the scanner runs ahead of the output.
	tdsn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Serialize each group one byte per cycle while m_tready is high, tagging its final byte.
	tdsn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_char   (m_tdata),
		.out_last   (m_tlast)
	);

endmodule

// File: rtl/tdsn_front.sv
module tdsn_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tdsn_pkg::CHAR_W-1:0]     in_char,
	input  logic                            in_eoi,
	output logic                            push,
	output tdsn_pkg::bundle_t               push_data,
	input  logic                            q_full
);
	import tdsn_pkg::*;

	logic [CHAR_W-1:0] held_q [2];
	logic [1:0]        held_cnt_q;
	logic              space_q;

	logic [CHAR_W-1:0] nxt_held [2];
	logic [1:0]        nxt_cnt;
	logic              nxt_space;
	bundle_t           bund;
	logic              accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Scan up to three queued bytes: held lookahead plus the new byte.
	always_comb begin
		logic [CHAR_W-1:0] q [5];
		logic [1:0]        hc;
		logic [1:0]        len;
		logic [1:0]        pos;
		logic [1:0]        avail;
		logic [1:0]        used;
		logic [CHAR_W-1:0] a;
		logic [CHAR_W-1:0] m;
		logic [CHAR_W-1:0] t;
		logic              hold;
		logic              done;
		logic              sp;
		logic [CNT_W-1:0]  n;

		for (int k = 0; k < 5; k++) q[k] = CH_NONE;
		hc = (held_cnt_q > 2'd2) ? 2'd2 : held_cnt_q;
		unique case (hc)
			2'd0: begin
				q[0] = in_char;
			end
			2'd1: begin
				q[0] = held_q[0];
				q[1] = in_char;
			end
			default: begin
				q[0] = held_q[0];
				q[1] = held_q[1];
				q[2] = in_char;
			end
		endcase
		len = hc + {1'b0, !in_eoi};

		nxt_held[0] = held_q[0];
		nxt_held[1] = held_q[1];
		nxt_cnt     = 2'd0;
		sp          = space_q;
		pos         = 2'd0;
		done        = 1'b0;
		n           = '0;
		bund.bytes  = '0;
		a = CH_NONE; m = CH_NONE; t = CH_NONE;
		avail = 2'd0; used = 2'd1; hold = 1'b0;

		for (int it = 0; it < 3; it++) begin
			if (!done && pos < len) begin
				a     = q[3'(pos)];
				avail = len - pos;
				m     = CH_NONE;
				used  = 2'd1;
				hold  = 1'b0;
				if (is_lead(a) && (avail == 2'd1 || (a == CH_QUEST && avail == 2'd2 &&
						q[3'(pos) + 3'd1] == CH_QUEST))) begin
					hold = !in_eoi;
				end else if (a == CH_QUEST) begin
					if (q[3'(pos) + 3'd1] == CH_QUEST) begin
						m    = tri_map(q[3'(pos) + 3'd2]);
						used = 2'd3;
					end
				end else if (is_lead(a)) begin
					m    = di_map(a, q[3'(pos) + 3'd1]);
					used = 2'd2;
				end

				if (hold) begin
					// Keep the open lookahead for the next item.
					nxt_held[0] = q[3'(pos)];
					nxt_held[1] = q[3'(pos) + 3'd1];
					nxt_cnt     = avail;
					done        = 1'b1;
				end else begin
					t   = (m != CH_NONE) ? m : a;
					pos = pos + ((m != CH_NONE) ? used : 2'd1);
					if (is_blank(t)) begin
						sp = 1'b1;
					end else if (t == CH_LF) begin
						sp = 1'b0;
						bund.bytes[n[1:0]] = t;
						n = n + 1'b1;
					end else begin
						if (sp) begin
							sp = 1'b0;
							bund.bytes[n[1:0]] = CH_SPACE;
							n = n + 1'b1;
						end
						bund.bytes[n[1:0]] = t;
						n = n + 1'b1;
					end
				end
			end
		end

		if (in_eoi && sp) begin
			sp = 1'b0;
			bund.bytes[n[1:0]] = CH_SPACE;
			n = n + 1'b1;
		end
		bund.cnt  = n;
		nxt_space = sp;
	end

	assign push      = accept && (bund.cnt != '0);
	assign push_data = bund;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			space_q    <= 1'b0;
		end else if (accept) begin
			held_cnt_q <= nxt_cnt;
			space_q    <= nxt_space;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && nxt_cnt != 2'd0) begin
			held_q[0] <= nxt_held[0];
			held_q[1] <= nxt_held[1];
		end
	end

endmodule

// File: rtl/tdsn_queue.sv
module tdsn_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tdsn_pkg::bundle_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output tdsn_pkg::bundle_t head
);
	import tdsn_pkg::*;

	bundle_t           slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

endmodule

// File: rtl/tdsn_back.sv
module tdsn_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  tdsn_pkg::bundle_t           head,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tdsn_pkg::CHAR_W-1:0] out_char,
	output logic                        out_last
);
	import tdsn_pkg::*;

	logic [1:0]        idx_q;
	logic              valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              load;
	logic              is_last;

	assign load    = head_valid && (!valid_q || out_ready);
	assign is_last = ({1'b0, idx_q} + 1'b1) == head.cnt;
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= head.bytes[idx_q];
			last_q <= is_last;
		end
	end

	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

endmodule
